[design/ascii_hex_frame_encoder_assert.svh]
// Assertion macros used by the checker module of the frame encoder.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASCII_HEX_FRAME_ENCODER_ASSERT_SVH
`define ASCII_HEX_FRAME_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HEXF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HEXF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/hexf_pkg.sv]
package hexf_pkg;

  localparam int unsigned NumChars = 6;
  localparam int unsigned CntW     = $clog2(NumChars + 1);

  localparam logic [6:0] CH_T  = 7'h54;
  localparam logic [6:0] CH_X  = 7'h58;
  localparam logic [6:0] CH_S  = 7'h53;
  localparam logic [6:0] CH_CR = 7'h0D;
  localparam logic [6:0] CH_LF = 7'h0A;
  localparam logic [6:0] CH_0  = 7'h30;
  localparam logic [6:0] CH_A  = 7'h41;

  typedef enum logic [1:0] {
    POS_ADDR  = 2'd0,
    POS_IDENT = 2'd1,
    POS_DATA  = 2'd2
  } pos_e;

  typedef logic [6:0] char_t;

  // One encoded input word: the characters it expands to, in order.
  typedef struct packed {
    char_t [NumChars-1:0] chars;
    logic  [CntW-1:0]     count;
    logic                 closes;
  } enc_word_t;

  function automatic char_t hex_digit(input logic [3:0] nib);
    char_t ch;
    if (nib < 4'd10) begin
      ch = CH_0 + {3'd0, nib};
    end else begin
      ch = CH_A + {3'd0, nib - 4'd10};
    end
    return ch;
  endfunction

endpackage

[design/hexf_if.sv]
interface hexf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       with_checksum;
  logic       last;

  modport source (output valid, byte_value, with_checksum, last, input ready);
  modport sink   (input valid, byte_value, with_checksum, last, output ready);
endinterface

interface hexf_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       end_of_frame;

  modport source (output valid, out_char, end_of_frame, input ready);
  modport sink   (input valid, out_char, end_of_frame, output ready);
endinterface

[design/ascii_hex_frame_encoder.sv]
// Channel | Dir | Word contents
// in_i    | in  | byte_value[7:0], with_checksum, last
// out_o   | out | out_char[6:0], end_of_frame
//
// An accepted byte is encoded in the cycle it arrives and its 2 to 6 characters
// leave one per cycle from the output shift register while out_o is ready.
// The next byte is taken in the cycle the final character of the previous one leaves.
// A stall on out_o holds the current character and blocks in_i once that is the final one.
// Reset clears the frame position, running XOR, checksum mode and pending characters.
module ascii_hex_frame_encoder (
  input logic        clk_i,
  input logic        rst_ni,
  hexf_in_if.sink    in_i,
  hexf_out_if.source out_o
);

  hexf_pkg::enc_word_t word;
  logic                can_load;
  logic                take;

  assign in_i.ready = can_load;
  assign take       = in_i.valid && can_load;

  hexf_encode u_encode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .byte_value_i   (in_i.byte_value),
    .with_checksum_i(in_i.with_checksum),
    .last_i         (in_i.last),
    .word_o         (word)
  );

  hexf_serial u_serial (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (take),
    .word_i        (word),
    .can_load_o    (can_load),
    .valid_o       (out_o.valid),
    .ready_i       (out_o.ready),
    .out_char_o    (out_o.out_char),
    .end_of_frame_o(out_o.end_of_frame)
  );

endmodule

[design/hexf_encode.sv]
module hexf_encode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          byte_value_i,
  input  logic                with_checksum_i,
  input  logic                last_i,
  output hexf_pkg::enc_word_t word_o
);

  hexf_pkg::pos_e  pos_q, pos_d;
  logic [6:0]      xor_q, xor_d;
  logic            mode_q, mode_d;
  hexf_pkg::char_t hi, lo;
  logic [6:0]      xor_next;

  assign hi       = hexf_pkg::hex_digit(byte_value_i[7:4]);
  assign lo       = hexf_pkg::hex_digit(byte_value_i[3:0]);
  assign xor_next = xor_q ^ hi ^ lo;

  always_comb begin
    word_o        = '0;
    pos_d         = pos_q;
    xor_d         = xor_q;
    mode_d        = mode_q;
    case (pos_q)
      hexf_pkg::POS_ADDR: begin
        word_o.chars[0] = hexf_pkg::CH_T;
        word_o.chars[1] = with_checksum_i ? hexf_pkg::CH_S : hexf_pkg::CH_X;
        word_o.chars[2] = hi;
        word_o.chars[3] = lo;
        word_o.count    = hexf_pkg::CntW'(4);
        pos_d           = hexf_pkg::POS_IDENT;
        xor_d           = hi ^ lo;
        mode_d          = with_checksum_i;
      end
      default: begin
        word_o.chars[0] = hi;
        word_o.chars[1] = lo;
        word_o.count    = hexf_pkg::CntW'(2);
        pos_d           = hexf_pkg::POS_DATA;
        xor_d           = xor_next;
        if (last_i) begin
          word_o.closes = 1'b1;
          if (mode_q) begin
            word_o.chars[2] = hexf_pkg::hex_digit({1'b0, xor_next[6:4]});
            word_o.chars[3] = hexf_pkg::hex_digit(xor_next[3:0]);
            word_o.chars[4] = hexf_pkg::CH_CR;
            word_o.chars[5] = hexf_pkg::CH_LF;
            word_o.count    = hexf_pkg::CntW'(6);
          end else begin
            word_o.chars[2] = hexf_pkg::CH_CR;
            word_o.chars[3] = hexf_pkg::CH_LF;
            word_o.count    = hexf_pkg::CntW'(4);
          end
          pos_d  = hexf_pkg::POS_ADDR;
          xor_d  = '0;
          mode_d = 1'b0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= hexf_pkg::POS_ADDR;
      xor_q  <= '0;
      mode_q <= 1'b0;
    end else if (take_i) begin
      pos_q  <= pos_d;
      xor_q  <= xor_d;
      mode_q <= mode_d;
    end
  end

endmodule

[design/hexf_serial.sv]
module hexf_serial (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  hexf_pkg::enc_word_t word_i,
  output logic                can_load_o,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [6:0]          out_char_o,
  output logic                end_of_frame_o
);

  hexf_pkg::char_t [hexf_pkg::NumChars-1:0] chars_q, chars_d;
  logic [hexf_pkg::CntW-1:0]                rem_q, rem_d;
  logic                                     closes_q, closes_d;
  logic                                     fire;
  logic                                     on_final;

  assign valid_o        = (rem_q != '0);
  assign fire           = valid_o && ready_i;
  assign on_final       = (rem_q == hexf_pkg::CntW'(1));
  assign can_load_o     = !valid_o || (on_final && ready_i);
  assign out_char_o     = chars_q[0];
  assign end_of_frame_o = on_final && closes_q;

  always_comb begin
    chars_d  = chars_q;
    rem_d    = rem_q;
    closes_d = closes_q;
    if (load_i) begin
      chars_d  = word_i.chars;
      rem_d    = word_i.count;
      closes_d = word_i.closes;
    end else if (fire) begin
      chars_d  = {hexf_pkg::char_t'(0), chars_q[hexf_pkg::NumChars-1:1]};
      rem_d    = rem_q - hexf_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chars_q  <= chars_d;
    closes_q <= closes_d;
  end

endmodule

[design/hexf_checker.sv]
`include "ascii_hex_frame_encoder_assert.svh"

module hexf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [6:0] out_char_i,
  input logic       end_of_frame_i
);

  logic       out_fire;
  logic       opens_frame;
  logic       stalled;
  logic [7:0] out_word;

  assign out_fire    = out_valid_i && out_ready_i;
  assign opens_frame = !out_valid_i || (out_char_i == hexf_pkg::CH_T);
  assign stalled     = out_valid_i && !out_ready_i;
  assign out_word    = {out_char_i, end_of_frame_i};

  // A frame always closes on a line feed.
  `HEXF_ASSERT_SAME(a_eof_is_lf, out_valid_i && end_of_frame_i, out_char_i == hexf_pkg::CH_LF)

  // The character after a frame end opens the next frame.
  `HEXF_ASSERT_NEXT(a_frame_opens_t, out_fire && end_of_frame_i, opens_frame)

  // A new word is only taken when the output is free or draining its last character.
  `HEXF_ASSERT_SAME(a_take_needs_room, in_valid_i && in_ready_i, !out_valid_i || out_ready_i)

  // A stalled character holds.
  `HEXF_ASSERT_NEXT(a_stall_holds, stalled, out_valid_i && $stable(out_word))

endmodule

bind ascii_hex_frame_encoder hexf_checker u_hexf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_char_i    (out_o.out_char),
  .end_of_frame_i(out_o.end_of_frame)
);
